[rtl/core/mme_pkg.sv]
`default_nettype none

package mme_pkg;

  // Field and register widths fixed by the interface
  localparam int DIM_W = 6;
  localparam int IDX_W = 5;
  localparam int IN_W  = 16;
  localparam int OUT_W = 32;

  // Accumulator: up to 63 terms of at most 2^30 each, plus sign
  localparam int ACC_W = 39;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_COMPUTE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LEFT_ROWS  = 2'd0,
    CFG_INNER_LEN  = 2'd1,
    CFG_RIGHT_COLS = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/matrix_multiply_engine.sv]
// Matrix multiply engine with a left and a right element store.
// Input channel (in_valid_i / in_stall_o) carries one word per item: an
// opcode, a row, a column and a Q8.8 element. Opcode 0 writes a left element,
// 1 writes a right element, 2 computes one product element as the dot product
// of a left row and a right column over inner_len terms.
// Output channel (out_valid_o / out_stall_i) returns one word per item: a
// Q16.16 product (zero for writes and rejected items) and a status.
// Dimensions are set through the cfg_we_i write port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// A write item shows its result the cycle after acceptance when the output
// register is free; a new write can be accepted every cycle while none is held.
// A compute item reads one memory read pair per cycle over inner_len (capped at
// MAX_DIM), then a registered multiply and accumulate; input stalls until done.
// When the receiver stalls, one finished result waits in the output register
// while the next item is taken; a second result then holds in the engine and
// the input stalls until the output drains.
// Reset sets all dimensions to 32 and empties the output; the element stores
// are not cleared and must be written before they are read.
`default_nettype none

module matrix_multiply_engine #(
  parameter int MAX_DIM   = 32,
  parameter int ELEM_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [1:0]                           cfg_idx_i,
  input  wire logic [mme_pkg::DIM_W-1:0]            cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           opcode_i,
  input  wire logic [mme_pkg::IDX_W-1:0]            row_i,
  input  wire logic [mme_pkg::IDX_W-1:0]            col_i,
  input  wire logic signed [mme_pkg::IN_W-1:0]      elem_value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [mme_pkg::OUT_W-1:0]          product_value_o,
  output logic [1:0]                                status_o
);
  import mme_pkg::*;

  localparam int VB    = (ELEM_BITS < IN_W) ? ELEM_BITS : IN_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [DIM_W-1:0] left_rows_q, inner_len_q, right_cols_q;
  logic [DIM_W-1:0] nr, nk, nc;

  // Sequencer state
  state_e           state_q, state_d;
  logic [IDX_W-1:0] row_q, col_q;
  logic [DIM_W-1:0] cnt_q;
  logic             rd_vld_q, prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [2*VB-1:0]   prod_q;

  // Element stores
  logic [VB-1:0]        l_mem [DEPTH];
  logic [VB-1:0]        r_mem [DEPTH];
  logic signed [VB-1:0] l_rdata_q, r_rdata_q;
  logic [AW-1:0]        w_addr, l_raddr, r_raddr;

  // Result path
  logic signed [OUT_W-1:0] hold_val_q, out_val_q, res_val, sat_val;
  status_e                 hold_st_q, out_st_q, res_st, sat_st;
  logic                    out_valid_q;

  // Control strobes
  logic accept, start, l_we, r_we, issue, done, res_fire, slot_free;
  logic load_out, load_hold;
  logic row_lt_nr, row_lt_nk, col_lt_nk, col_lt_nc;

  // Limit dimensions to the store size
  assign nr = (32'(left_rows_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : left_rows_q;
  assign nk = (32'(inner_len_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : inner_len_q;
  assign nc = (32'(right_cols_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : right_cols_q;

  assign row_lt_nr = ({1'b0, row_i} < nr);
  assign row_lt_nk = ({1'b0, row_i} < nk);
  assign col_lt_nk = ({1'b0, col_i} < nk);
  assign col_lt_nc = ({1'b0, col_i} < nc);

  // Store addresses: row * MAX_DIM + col
  assign w_addr  = AW'(32'(row_i) * 32'(MAX_DIM) + 32'(col_i));
  assign l_raddr = AW'(32'(row_q) * 32'(MAX_DIM) + 32'(cnt_q));
  assign r_raddr = AW'(32'(cnt_q) * 32'(MAX_DIM) + 32'(col_q));

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Saturate the finished sum
  always_comb begin
    sat_val = acc_q[OUT_W-1:0];
    sat_st  = ST_OK;
    if (acc_q > SAT_HI) begin
      sat_val = 32'sh7FFF_FFFF;
      sat_st  = ST_SAT;
    end else if (acc_q < SAT_LO) begin
      sat_val = 32'sh8000_0000;
      sat_st  = ST_SAT;
    end
  end

  // Decode items and sequence the dot product
  always_comb begin
    start    = 1'b0;
    l_we     = 1'b0;
    r_we     = 1'b0;
    issue    = 1'b0;
    done     = 1'b0;
    res_fire = 1'b0;
    res_val  = '0;
    res_st   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_e'(opcode_i))
            OP_WR_LEFT: begin
              res_fire = 1'b1;
              if (row_lt_nr && col_lt_nk) begin
                l_we = 1'b1;
              end else begin
                res_st = ST_RANGE;
              end
            end
            OP_WR_RIGHT: begin
              res_fire = 1'b1;
              if (row_lt_nk && col_lt_nc) begin
                r_we = 1'b1;
              end else begin
                res_st = ST_RANGE;
              end
            end
            OP_COMPUTE: begin
              if (row_lt_nr && col_lt_nc) begin
                start = 1'b1;
              end else begin
                res_fire = 1'b1;
                res_st   = ST_RANGE;
              end
            end
            default: begin
              res_fire = 1'b1;
              res_st   = ST_RANGE;
            end
          endcase
        end
      end
      S_RUN: begin
        issue = (cnt_q < nk);
        done  = !issue && !rd_vld_q && !prod_vld_q;
        if (done) begin
          res_fire = 1'b1;
          res_val  = sat_val;
          res_st   = sat_st;
        end
      end
      S_DONE: begin
        res_fire = 1'b1;
        res_val  = hold_val_q;
        res_st   = hold_st_q;
      end
      default: begin
      end
    endcase
    load_out  = res_fire && slot_free;
    load_hold = res_fire && !slot_free && (state_q != S_DONE);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_RUN;
        end else if (load_hold) begin
          state_d = S_DONE;
        end
      end
      S_RUN: begin
        if (done) begin
          state_d = slot_free ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      left_rows_q  <= DIM_RESET;
      inner_len_q  <= DIM_RESET;
      right_cols_q <= DIM_RESET;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      prod_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (start) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + DIM_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_LEFT_ROWS:  left_rows_q  <= cfg_data_i;
          CFG_INNER_LEN:  inner_len_q  <= cfg_data_i;
          CFG_RIGHT_COLS: right_cols_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers: capture indices, multiply, accumulate, hold results
  always_ff @(posedge clk_i) begin
    if (start) begin
      row_q <= row_i;
      col_q <= col_i;
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (rd_vld_q) begin
      prod_q <= l_rdata_q * r_rdata_q;
    end
    if (load_hold) begin
      hold_val_q <= res_val;
      hold_st_q  <= res_st;
    end
    if (load_out) begin
      out_val_q <= res_val;
      out_st_q  <= res_st;
    end
  end

  // Left store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (l_we) begin
      l_mem[w_addr] <= elem_value_i[VB-1:0];
    end
    if (issue) begin
      l_rdata_q <= l_mem[l_raddr];
    end
  end

  // Right store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (r_we) begin
      r_mem[w_addr] <= elem_value_i[VB-1:0];
    end
    if (issue) begin
      r_rdata_q <= r_mem[r_raddr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign product_value_o = out_val_q;
  assign status_o        = out_st_q;

  // The read and multiply pipeline is busy only during a compute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q || prod_vld_q) |-> (state_q == S_RUN))
    else $error("mme: pipeline active outside compute");

  // A held result exists only while the output register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> out_valid_q)
    else $error("mme: result held with output register empty");

  // A saturated result sits at one of the two bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q == ST_SAT)) |->
      ((out_val_q == 32'sh7FFF_FFFF) || (out_val_q == 32'sh8000_0000)))
    else $error("mme: saturated result off the bound");

  // A rejected item returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q == ST_RANGE)) |-> (out_val_q == '0))
    else $error("mme: rejected item with nonzero product");

endmodule

`default_nettype wire

[tb/mme_checker.sv]
`default_nettype none

module mme_checker
  import mme_pkg::*;
#(
  parameter int MAX_DIM = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [DIM_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire logic [1:0]              opcode_i,
  input  wire logic [IDX_W-1:0]        row_i,
  input  wire logic [IDX_W-1:0]        col_i,
  input  wire logic signed [IN_W-1:0]  elem_value_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_stall_i,
  input  wire logic signed [OUT_W-1:0] product_value_i,
  input  wire logic [1:0]              status_i,
  output int                           mismatch_cnt_o,
  output int                           words_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    status_e                 status;
  } product_word_t;

  // Shadow copy of the dimension registers and both element stores
  logic [DIM_W-1:0]       rows_q, inner_q, cols_q;
  logic signed [IN_W-1:0] left_elems  [MAX_DIM*MAX_DIM];
  logic signed [IN_W-1:0] right_elems [MAX_DIM*MAX_DIM];
  product_word_t          owed_words [$];

  function automatic int clip_dim(logic [DIM_W-1:0] d);
    return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
  endfunction

  // Apply one input word to the shadow state and return the word it should produce
  function automatic product_word_t predict_word(logic [1:0] op, logic [IDX_W-1:0] r,
                                                 logic [IDX_W-1:0] c,
                                                 logic signed [IN_W-1:0] v);
    product_word_t w;
    int            nr, nk, nc, l;
    longint        sum;
    nr = clip_dim(rows_q);
    nk = clip_dim(inner_q);
    nc = clip_dim(cols_q);
    w.value  = '0;
    w.status = ST_OK;
    sum      = 0;
    case (op)
      OP_WR_LEFT: begin
        if (int'(r) < nr && int'(c) < nk) left_elems[r*MAX_DIM + c] = v;
        else w.status = ST_RANGE;
      end
      OP_WR_RIGHT: begin
        if (int'(r) < nk && int'(c) < nc) right_elems[r*MAX_DIM + c] = v;
        else w.status = ST_RANGE;
      end
      OP_COMPUTE: begin
        if (int'(r) < nr && int'(c) < nc) begin
          for (l = 0; l < nk; l++) begin
            sum += longint'(left_elems[r*MAX_DIM + l]) * longint'(right_elems[l*MAX_DIM + c]);
          end
          // Clamp to the Q16.16 range and flag it
          if (sum > SUM_MAX) begin
            sum      = SUM_MAX;
            w.status = ST_SAT;
          end else if (sum < SUM_MIN) begin
            sum      = SUM_MIN;
            w.status = ST_SAT;
          end
          w.value = OUT_W'(sum);
        end else begin
          w.status = ST_RANGE;
        end
      end
      default: w.status = ST_RANGE;
    endcase
    return w;
  endfunction

  // Compare each delivered word with the oldest prediction, then log new words
  always @(posedge clk_i or negedge rst_ni) begin
    product_word_t exp_w;
    if (!rst_ni) begin
      rows_q         = DIM_RESET;
      inner_q        = DIM_RESET;
      cols_q         = DIM_RESET;
      mismatch_cnt_o = 0;
      owed_words.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_words.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= 10)
            $display("%t: unexpected word: value %0d status %0d", $realtime,
                     product_value_i, status_i);
        end else begin
          exp_w = owed_words.pop_front();
          if (product_value_i !== exp_w.value || status_i !== exp_w.status) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= 10)
              $display("%t: mismatch: value exp %0d got %0d, status exp %0d got %0d",
                       $realtime, exp_w.value, product_value_i, exp_w.status, status_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        owed_words.push_back(predict_word(opcode_i, row_i, col_i, elem_value_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEFT_ROWS:  rows_q  = cfg_data_i;
          CFG_INNER_LEN:  inner_q = cfg_data_i;
          CFG_RIGHT_COLS: cols_q  = cfg_data_i;
          default: ;
        endcase
      end
    end
    words_owed_o = owed_words.size();
  end

endmodule

`default_nettype wire

[tb/tb_matrix_multiply_engine.sv]
`default_nettype none

module tb_matrix_multiply_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import mme_pkg::*;

  localparam int          MAX_DIM     = 32;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          PHASES      = 16;
  localparam int          PHASE_WORDS = 80;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic                    clk;
  logic                    rst_n         = 1'b0;
  logic                    cfg_we        = 1'b0;
  logic [1:0]              cfg_idx       = CFG_LEFT_ROWS;
  logic [DIM_W-1:0]        cfg_data      = '0;
  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [1:0]              opcode        = OP_WR_LEFT;
  logic [IDX_W-1:0]        row           = '0;
  logic [IDX_W-1:0]        col           = '0;
  logic signed [IN_W-1:0]  elem_value    = '0;
  logic                    out_valid;
  logic                    out_stall     = 1'b0;
  logic signed [OUT_W-1:0] product_value;
  logic [1:0]              status;

  int mismatch_cnt;
  int words_owed;
  int cycle_cnt     = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // Effective dimensions and which store entries hold a value
  int dim_rows  = MAX_DIM;
  int dim_inner = MAX_DIM;
  int dim_cols  = MAX_DIM;
  bit left_set  [MAX_DIM][MAX_DIM];
  bit right_set [MAX_DIM][MAX_DIM];

  matrix_multiply_engine u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .row_i           (row),
    .col_i           (col),
    .elem_value_i    (elem_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .product_value_o (product_value),
    .status_o        (status)
  );

  mme_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .row_i           (row),
    .col_i           (col),
    .elem_value_i    (elem_value),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .product_value_i (product_value),
    .status_i        (status),
    .mismatch_cnt_o  (mismatch_cnt),
    .words_owed_o    (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) out_stall = ($urandom_range(99) < stall_pct);

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL matrix_multiply_engine");
      $finish;
    end
  end

  function automatic logic signed [IN_W-1:0] rand_elem();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0:       return IN_W'(16'h8000);
          1:       return IN_W'(16'h7fff);
          2:       return '0;
          default: return IN_W'(16'hffff);
        endcase
      end
      1:       return IN_W'($urandom);
      default: return IN_W'(int'($urandom_range(1023)) - 512);
    endcase
  endfunction

  // Drive one word and hold it until taken; enter and leave on a falling edge.
  // A compute that would touch an unwritten entry becomes a write of that entry.
  task automatic send_word(logic [1:0] op, int r, int c, logic signed [IN_W-1:0] v);
    logic [1:0] use_op;
    int         use_r, use_c, l;
    use_op = op;
    use_r  = r;
    use_c  = c;
    if (op == OP_COMPUTE && r < dim_rows && c < dim_cols) begin
      for (l = 0; l < dim_inner; l++) begin
        if (use_op == OP_COMPUTE && !left_set[r][l]) begin
          use_op = OP_WR_LEFT;
          use_c  = l;
        end else if (use_op == OP_COMPUTE && !right_set[l][c]) begin
          use_op = OP_WR_RIGHT;
          use_r  = l;
        end
      end
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    opcode     = use_op;
    row        = IDX_W'(use_r);
    col        = IDX_W'(use_c);
    elem_value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Record entries that now hold a value
    if (use_op == OP_WR_LEFT && use_r < dim_rows && use_c < dim_inner)
      left_set[use_r][use_c] = 1'b1;
    if (use_op == OP_WR_RIGHT && use_r < dim_inner && use_c < dim_cols)
      right_set[use_r][use_c] = 1'b1;
    @(negedge clk);
  endtask

  // Hold off the input until every predicted word has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (words_owed != 0) @(negedge clk);
  endtask

  // Reprogram all three dimensions while the engine is idle
  task automatic write_dims(int r, int k, int c);
    drain_results();
    repeat (8) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = CFG_LEFT_ROWS;
    cfg_data = DIM_W'(r);
    @(negedge clk);
    cfg_idx  = CFG_INNER_LEN;
    cfg_data = DIM_W'(k);
    @(negedge clk);
    cfg_idx  = CFG_RIGHT_COLS;
    cfg_data = DIM_W'(c);
    @(negedge clk);
    cfg_we    = 1'b0;
    dim_rows  = (r > MAX_DIM) ? MAX_DIM : r;
    dim_inner = (k > MAX_DIM) ? MAX_DIM : k;
    dim_cols  = (c > MAX_DIM) ? MAX_DIM : c;
  endtask

  // Mostly in-range writes and computes, some noise with any opcode and index
  task automatic random_word();
    logic [1:0] op;
    int         r, c, pick;
    pick = $urandom_range(99);
    op   = 2'($urandom_range(3));
    r    = $urandom_range(31);
    c    = $urandom_range(31);
    if (pick >= 10 && pick < 55) begin
      op = ($urandom_range(1) == 0) ? OP_WR_LEFT : OP_WR_RIGHT;
      if (op == OP_WR_LEFT && dim_rows > 0 && dim_inner > 0) begin
        r = $urandom_range(dim_rows - 1);
        c = $urandom_range(dim_inner - 1);
      end else if (op == OP_WR_RIGHT && dim_inner > 0 && dim_cols > 0) begin
        r = $urandom_range(dim_inner - 1);
        c = $urandom_range(dim_cols - 1);
      end
    end else if (pick >= 55) begin
      op = OP_COMPUTE;
      if (dim_rows > 0 && dim_cols > 0) begin
        r = $urandom_range(dim_rows - 1);
        c = $urandom_range(dim_cols - 1);
      end
    end
    send_word(op, r, c, rand_elem());
  endtask

  initial begin
    int ph, n;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: saturation both ways, plain products, every range reject
    write_dims(2, 3, 2);
    send_word(OP_WR_LEFT,  0, 0, IN_W'(16'h8000));
    send_word(OP_WR_LEFT,  0, 1, IN_W'(16'h8000));
    send_word(OP_WR_LEFT,  0, 2, IN_W'(16'h8000));
    send_word(OP_WR_RIGHT, 0, 0, IN_W'(16'h8000));
    send_word(OP_WR_RIGHT, 1, 0, IN_W'(16'h8000));
    send_word(OP_WR_RIGHT, 2, 0, IN_W'(16'h8000));
    send_word(OP_COMPUTE,  0, 0, '0);
    send_word(OP_WR_RIGHT, 0, 1, IN_W'(16'h7fff));
    send_word(OP_WR_RIGHT, 1, 1, IN_W'(16'h7fff));
    send_word(OP_WR_RIGHT, 2, 1, IN_W'(16'h7fff));
    send_word(OP_COMPUTE,  0, 1, '0);
    send_word(OP_WR_LEFT,  1, 0, IN_W'(16'h7fff));
    send_word(OP_WR_LEFT,  1, 1, '0);
    send_word(OP_WR_LEFT,  1, 2, IN_W'(16'hffff));
    send_word(OP_COMPUTE,  1, 0, '0);
    send_word(OP_COMPUTE,  1, 1, IN_W'(16'hffff));
    send_word(OP_WR_LEFT,  2, 0, IN_W'(16'h1234));
    send_word(OP_WR_LEFT,  0, 3, IN_W'(16'h1234));
    send_word(OP_WR_RIGHT, 3, 0, IN_W'(16'h1234));
    send_word(OP_WR_RIGHT, 0, 2, IN_W'(16'h1234));
    send_word(OP_COMPUTE,  31, 31, '0);
    send_word(OP_UNUSED,   31, 31, IN_W'(16'hffff));

    // Random phases: fixed shapes first, among them zero and oversized dimensions, then small shapes
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_dims(4, 4, 4);
        1:       write_dims(0, 5, 3);
        2:       write_dims(3, 0, 4);
        3:       write_dims(4, 4, 0);
        4:       write_dims(63, 2, 63);
        5:       write_dims(1, 63, 1);
        6:       write_dims(33, 1, 33);
        7:       write_dims(32, 32, 32);
        8:       write_dims(1, 1, 1);
        default: write_dims($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) drain_results();
        random_word();
      end
    end

    drain_results();
    repeat (64) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS matrix_multiply_engine");
    end else begin
      $display("FAIL matrix_multiply_engine");
    end
    $finish;
  end

endmodule

`default_nettype wire

[matrix_multiply_engine.f]
rtl/core/mme_pkg.sv
rtl/core/matrix_multiply_engine.sv
tb/mme_checker.sv
tb/tb_matrix_multiply_engine.sv
